// ===== sv/ihsp_pkg.sv =====
// Package for the image header size parser: phase, format and status codes,
// signature byte tables and default sizes.
// Depends on nothing; imported by image_header_size_parser_top.
package ihsp_pkg;

  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned IN_DATA_W         = 8;
  localparam int unsigned OUT_DATA_W        = 72;

  typedef enum logic [3:0] {
    PH_SIG   = 4'd0,
    PH_PNG   = 4'd1,
    PH_GIF   = 4'd2,
    PH_JM0   = 4'd3,
    PH_JM1   = 4'd4,
    PH_JL0   = 4'd5,
    PH_JL1   = 4'd6,
    PH_JSKIP = 4'd7,
    PH_JSOF  = 4'd8,
    PH_JHOLD = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    FMT_PNG     = 2'd0,
    FMT_JPEG    = 2'd1,
    FMT_GIF     = 2'd2,
    FMT_UNKNOWN = 2'd3
  } format_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNK_SIG   = 3'd1,
    ST_SHORT     = 3'd2,
    ST_BAD_IHDR  = 3'd3,
    ST_BAD_MARK  = 3'd4,
    ST_NO_SOF    = 3'd5,
    ST_TRUNC     = 3'd6
  } status_e;

  // Bit positions in the signature candidate flags.
  localparam int unsigned F_PNG   = 0;
  localparam int unsigned F_JPEG  = 1;
  localparam int unsigned F_GIF89 = 2;
  localparam int unsigned F_GIF87 = 3;

  localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                         8'h0D, 8'h0A, 8'h1A, 8'h0A};
  // Only the first six entries of the GIF tables are compared.
  localparam logic [7:0] GIF89_SIG [8] = '{8'h47, 8'h49, 8'h46, 8'h38,
                                           8'h39, 8'h61, 8'h00, 8'h00};
  localparam logic [7:0] GIF87_SIG [8] = '{8'h47, 8'h49, 8'h46, 8'h38,
                                           8'h37, 8'h61, 8'h00, 8'h00};
  localparam logic [7:0] IHDR_NAME [4] = '{8'h49, 8'h48, 8'h44, 8'h52};

  localparam logic [7:0] JPEG_MARK = 8'hFF;
  localparam logic [7:0] JPEG_SOI  = 8'hD8;
  localparam logic [7:0] SOF_FIRST = 8'hC0;
  localparam logic [7:0] SOF_LAST  = 8'hC3;

endpackage

// ===== sv/image_header_size_parser_top.sv =====
// Image header size parser, top level: signature detection, PNG/GIF field
// capture and the JPEG segment walker, with a one-entry result register.
// Depends on ihsp_pkg.
//
// Usage: the bytes of one image file arrive on the slave stream, one byte per
// request in tdata, with tlast on the final byte of the file. For every file
// exactly one result leaves on the master stream: format, status, width and
// height. It appears in the cycle after the byte that decides it; bytes after
// the decision are consumed and dropped, and all parser state returns to its
// reset value after the byte that carries tlast.
// Throughput is one byte per cycle: the whole step for a byte is one pass of
// compare and counter logic from the state registers into the state and
// result registers. The result register is bypassed on the ready side, so a
// new byte is taken in the same cycle that a waiting result is taken. When
// the receiver stalls with a result held, s_axis_tready_o drops until it is
// taken. Reset (rst_ni low) clears the parser state and empties the result
// register; no clearing pass is needed.
module image_header_size_parser_top #(
  parameter int unsigned POSITION_BITS = ihsp_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [ihsp_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,  // [7:0] data_byte
  input  logic                                s_axis_tlast_i,  // last_byte
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [1:0] image_format, [4:2] status, [36:5] width, [68:37] height, rest zero
  output logic [ihsp_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);
  import ihsp_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  phase_e                   phase_q, phase_d;
  format_e                  fmt_q, fmt_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [3:0]               flags_q, flags_d;
  logic [15:0]              seg_q, seg_d;
  logic [2:0]               fo_q, fo_d;
  logic [31:0]              w_q, w_d;
  logic [31:0]              h_q, h_d;
  logic                     done_q, done_d;
  status_e                  held_q, held_d;

  logic                     out_valid_q;
  logic [OUT_DATA_W-1:0]    out_data_q;

  logic                     in_fire;
  logic                     emit;
  format_e                  e_fmt;
  status_e                  e_st;
  logic [31:0]              e_w, e_h;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    logic [7:0]  b;
    logic        last;
    logic [2:0]  p;
    logic        sig_ph;
    logic        walk_en;
    logic        jd;
    status_e     st;
    logic [15:0] len;

    b       = s_axis_tdata_i;
    last    = s_axis_tlast_i;
    p       = pos_q[2:0];
    sig_ph  = (pos_q < POSITION_BITS'(8));
    walk_en = 1'b0;
    jd      = 1'b0;
    st      = ST_OK;
    len     = seg_q | {8'h00, b};

    phase_d = phase_q;
    fmt_d   = fmt_q;
    pos_d   = pos_q;
    flags_d = flags_q;
    seg_d   = seg_q;
    fo_d    = fo_q;
    w_d     = w_q;
    h_d     = h_q;
    done_d  = done_q;
    held_d  = held_q;
    emit    = 1'b0;
    e_fmt   = FMT_UNKNOWN;
    e_st    = ST_OK;
    e_w     = '0;
    e_h     = '0;

    if (in_fire) begin
      if (!done_q) begin
        if (sig_ph) begin
          if (b != PNG_SIG[p]) flags_d[F_PNG] = 1'b0;
          if (p < 3'd3 && b != ((p == 3'd1) ? JPEG_SOI : JPEG_MARK)) begin
            flags_d[F_JPEG] = 1'b0;
          end
          if (p < 3'd6) begin
            if (b != GIF89_SIG[p]) flags_d[F_GIF89] = 1'b0;
            if (b != GIF87_SIG[p]) flags_d[F_GIF87] = 1'b0;
          end
          if (p == 3'd6) w_d = {24'h0, b};
          if (p == 3'd7) w_d = w_q | {16'h0, b, 8'h00};
          if (flags_d[F_JPEG]) begin
            if (p == 3'd2) phase_d = PH_JM1;
            else if (p >= 3'd3 && phase_q != PH_JHOLD) walk_en = 1'b1;
          end
        end else if (phase_q != PH_PNG && phase_q != PH_GIF) begin
          walk_en = 1'b1;
        end

        // JPEG segment walker, one byte per step.
        if (walk_en) begin
          case (phase_q)
            PH_JM0: begin
              if (last) begin
                jd = 1'b1; st = ST_NO_SOF;
              end else if (b != JPEG_MARK) begin
                jd = 1'b1; st = ST_BAD_MARK;
              end else begin
                phase_d = PH_JM1;
              end
            end
            PH_JM1: begin
              if (b >= SOF_FIRST && b <= SOF_LAST) begin
                phase_d = PH_JSOF;
                fo_d    = 3'd0;
              end else begin
                phase_d = PH_JL0;
              end
              if (last) begin
                jd = 1'b1; st = ST_TRUNC;
              end
            end
            PH_JL0: begin
              seg_d   = {b, 8'h00};
              phase_d = PH_JL1;
              if (last) begin
                jd = 1'b1; st = ST_TRUNC;
              end
            end
            PH_JL1: begin
              if (len < 16'd2) begin
                jd = 1'b1; st = ST_BAD_MARK;
              end else if (last) begin
                jd = 1'b1; st = ST_NO_SOF;
              end else if (len == 16'd2) begin
                phase_d = PH_JM0;
                seg_d   = '0;
              end else begin
                seg_d   = len - 16'd2;
                phase_d = PH_JSKIP;
              end
            end
            PH_JSKIP: begin
              if (seg_q != '0) seg_d = seg_q - 16'd1;
              if (seg_d == '0) phase_d = PH_JM0;
              if (last) begin
                jd = 1'b1; st = ST_NO_SOF;
              end
            end
            PH_JSOF: begin
              if (fo_q == 3'd6) begin
                w_d = w_q | {24'h0, b};
                jd  = 1'b1;
                st  = ST_OK;
              end else begin
                if (fo_q == 3'd3) h_d = {16'h0, b, 8'h00};
                else if (fo_q == 3'd4) h_d = h_q | {24'h0, b};
                else if (fo_q == 3'd5) w_d = {16'h0, b, 8'h00};
                fo_d = fo_q + 3'd1;
                if (last) begin
                  jd = 1'b1; st = ST_TRUNC;
                end
              end
            end
            default: ;
          endcase
        end

        if (sig_ph) begin
          // A JPEG outcome before the eighth byte waits for the format decision.
          if (jd) begin
            held_d  = st;
            phase_d = PH_JHOLD;
          end
          if (p == 3'd7) begin
            if (flags_d[F_PNG]) begin
              fmt_d   = FMT_PNG;
              phase_d = PH_PNG;
              if (last) begin
                emit = 1'b1; e_fmt = FMT_PNG; e_st = ST_TRUNC;
              end
            end else if (flags_d[F_JPEG]) begin
              fmt_d = FMT_JPEG;
              if (phase_d == PH_JHOLD) begin
                emit = 1'b1; e_fmt = FMT_JPEG; e_st = held_d;
              end
            end else if (flags_d[F_GIF89] || flags_d[F_GIF87]) begin
              fmt_d   = FMT_GIF;
              phase_d = PH_GIF;
              if (last) begin
                emit = 1'b1; e_fmt = FMT_GIF; e_st = ST_TRUNC;
              end
            end else begin
              emit = 1'b1; e_fmt = FMT_UNKNOWN; e_st = ST_UNK_SIG;
            end
          end else if (last) begin
            emit = 1'b1; e_fmt = FMT_UNKNOWN; e_st = ST_SHORT;
          end
        end else if (phase_q == PH_PNG) begin
          if (pos_q >= POSITION_BITS'(12) && pos_q <= POSITION_BITS'(15)) begin
            if (b != IHDR_NAME[pos_q[1:0]]) begin
              emit = 1'b1; e_fmt = FMT_PNG; e_st = ST_BAD_IHDR;
            end
          end else if (pos_q >= POSITION_BITS'(16) && pos_q <= POSITION_BITS'(19)) begin
            w_d = (pos_q == POSITION_BITS'(16)) ? {24'h0, b} : {w_q[23:0], b};
          end else if (pos_q >= POSITION_BITS'(20) && pos_q <= POSITION_BITS'(23)) begin
            h_d = (pos_q == POSITION_BITS'(20)) ? {24'h0, b} : {h_q[23:0], b};
            if (pos_q == POSITION_BITS'(23)) begin
              emit = 1'b1; e_fmt = FMT_PNG; e_st = ST_OK;
            end
          end
          if (!emit && last) begin
            emit = 1'b1; e_fmt = FMT_PNG; e_st = ST_TRUNC;
          end
        end else if (phase_q == PH_GIF) begin
          if (pos_q == POSITION_BITS'(8)) begin
            h_d = {24'h0, b};
            if (last) begin
              emit = 1'b1; e_fmt = FMT_GIF; e_st = ST_TRUNC;
            end
          end else begin
            h_d  = h_q | {16'h0, b, 8'h00};
            emit = 1'b1; e_fmt = FMT_GIF; e_st = ST_OK;
          end
        end else if (jd) begin
          emit = 1'b1; e_fmt = FMT_JPEG; e_st = st;
        end

        if (emit) done_d = 1'b1;

        // Dimensions are taken before the end-of-file clear below.
        e_w = (e_st == ST_OK) ? w_d : 32'h0;
        e_h = (e_st == ST_OK) ? h_d : 32'h0;
      end

      if (pos_q != POS_MAX) pos_d = pos_q + POSITION_BITS'(1);

      // The end of a file puts every piece of parser state back to reset.
      if (last) begin
        phase_d = PH_SIG;
        fmt_d   = FMT_UNKNOWN;
        pos_d   = '0;
        flags_d = '1;
        seg_d   = '0;
        fo_d    = '0;
        w_d     = '0;
        h_d     = '0;
        done_d  = 1'b0;
        held_d  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG;
      fmt_q   <= FMT_UNKNOWN;
      pos_q   <= '0;
      flags_q <= '1;
      seg_q   <= '0;
      fo_q    <= '0;
      w_q     <= '0;
      h_q     <= '0;
      done_q  <= 1'b0;
      held_q  <= ST_OK;
    end else begin
      phase_q <= phase_d;
      fmt_q   <= fmt_d;
      pos_q   <= pos_d;
      flags_q <= flags_d;
      seg_q   <= seg_d;
      fo_q    <= fo_d;
      w_q     <= w_d;
      h_q     <= h_d;
      done_q  <= done_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_data_q <= {3'b000, e_h, e_w, e_st, e_fmt};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== test/image_header_size_parser_top_tb.sv =====
// Self-checking testbench for image_header_size_parser_top: streams whole image files
// (PNG, JPEG, GIF, noise, truncated) and checks each result against a parser
// predictor, or typed results. Depends on ihsp_pkg and image_header_size_parser_top.
module image_header_size_parser_top_tb;
  import ihsp_pkg::*;

  typedef struct {
    format_e     fmt;
    status_e     st;
    logic [31:0] w;
    logic [31:0] h;
  } header_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       has_exp;
    format_e    fmt;
    status_e    st;
  } stim_row_t;

  // Short hand-made files: a one-byte file, a PNG signature broken on its
  // last byte, a JPEG whose first segment length is 1 (held until byte 8),
  // and a GIF that ends right after the width field.
  localparam stim_row_t DIRECTED_ROWS [0:24] = '{
    '{8'hFF, 1'b1, 1'b1, FMT_UNKNOWN, ST_SHORT},
    '{8'h89, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h50, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h4E, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h47, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h0D, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h0A, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h1A, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h0B, 1'b1, 1'b1, FMT_UNKNOWN, ST_UNK_SIG},
    '{8'hFF, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'hD8, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'hFF, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'hE0, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h00, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h01, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'hAB, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'hCD, 1'b1, 1'b1, FMT_JPEG,    ST_BAD_MARK},
    '{8'h47, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h49, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h46, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h38, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h39, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'h61, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'hFF, 1'b0, 1'b0, FMT_UNKNOWN, ST_OK},
    '{8'hFF, 1'b1, 1'b1, FMT_GIF,     ST_TRUNC}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tlast_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // Parser state as the predictor sees it.
  phase_e      parse_phase;
  logic [31:0] byte_pos;
  logic [3:0]  candidates;
  logic [16:0] seg_left;
  logic [3:0]  fld_ofs;
  logic [31:0] width_acc;
  logic [31:0] height_acc;
  logic        decided;
  status_e     held_st;

  header_result_t header_expect_q[$];
  logic [7:0]     file_q[$];
  int             mismatch_count = 0;
  int             src_idle_pct = 35;
  int             snk_idle_pct = 77;
  int             hold_off_req = 0;

  image_header_size_parser_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic header_result_t make_result(format_e f, status_e s,
                                                 logic [31:0] w, logic [31:0] h);
    header_result_t r;
    r.fmt = f;
    r.st  = s;
    r.w   = (s == ST_OK) ? w : '0;
    r.h   = (s == ST_OK) ? h : '0;
    return r;
  endfunction

  function automatic void clear_parser();
    parse_phase = PH_SIG;
    byte_pos    = '0;
    candidates  = '1;
    seg_left    = '0;
    fld_ofs     = '0;
    width_acc   = '0;
    height_acc  = '0;
    decided     = 1'b0;
    held_st     = ST_OK;
  endfunction

  // One step of the JPEG segment walker; returns 1 once the outcome is fixed.
  function automatic bit jpeg_walk_step(input logic [7:0] b, input bit last,
                                        output status_e st);
    logic [16:0] seg_len;
    st = ST_OK;
    case (parse_phase)
      PH_JM0: begin
        if (last) begin
          st = ST_NO_SOF;
          return 1'b1;
        end
        if (b != JPEG_MARK) begin
          st = ST_BAD_MARK;
          return 1'b1;
        end
        parse_phase = PH_JM1;
      end
      PH_JM1: begin
        if (b >= SOF_FIRST && b <= SOF_LAST) begin
          parse_phase = PH_JSOF;
          fld_ofs = '0;
        end else begin
          parse_phase = PH_JL0;
        end
        if (last) begin
          st = ST_TRUNC;
          return 1'b1;
        end
      end
      PH_JL0: begin
        seg_left = {1'b0, b, 8'h00};
        parse_phase = PH_JL1;
        if (last) begin
          st = ST_TRUNC;
          return 1'b1;
        end
      end
      PH_JL1: begin
        seg_len = seg_left | {9'h0, b};
        if (seg_len < 2) begin
          st = ST_BAD_MARK;
          return 1'b1;
        end
        if (last) begin
          st = ST_NO_SOF;
          return 1'b1;
        end
        if (seg_len == 2) begin
          parse_phase = PH_JM0;
          seg_left = '0;
        end else begin
          seg_left = seg_len - 17'd2;
          parse_phase = PH_JSKIP;
        end
      end
      PH_JSKIP: begin
        if (seg_left > 0) seg_left = seg_left - 17'd1;
        if (seg_left == 0) parse_phase = PH_JM0;
        if (last) begin
          st = ST_NO_SOF;
          return 1'b1;
        end
      end
      PH_JSOF: begin
        if (fld_ofs == 3) begin
          height_acc = {16'h0, b, 8'h00};
        end else if (fld_ofs == 4) begin
          height_acc = height_acc | {24'h0, b};
        end else if (fld_ofs == 5) begin
          width_acc = {16'h0, b, 8'h00};
        end else if (fld_ofs == 6) begin
          width_acc = width_acc | {24'h0, b};
          return 1'b1;
        end
        fld_ofs = fld_ofs + 4'd1;
        if (last) begin
          st = ST_TRUNC;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Advances the predicted parser by one byte; returns 1 when the byte
  // decides the file, with the header result in r.
  function automatic bit predict_header_byte(input logic [7:0] b, input bit last,
                                             output header_result_t r);
    bit      hit;
    int      p;
    status_e st;
    hit = 1'b0;
    r = make_result(FMT_UNKNOWN, ST_OK, '0, '0);
    if (!decided) begin
      if (byte_pos < 8) begin
        p = int'(byte_pos[2:0]);
        if (b != PNG_SIG[p]) candidates[F_PNG] = 1'b0;
        if (p < 3 && b != (p == 1 ? JPEG_SOI : JPEG_MARK)) candidates[F_JPEG] = 1'b0;
        if (p < 6) begin
          if (b != GIF89_SIG[p]) candidates[F_GIF89] = 1'b0;
          if (b != GIF87_SIG[p]) candidates[F_GIF87] = 1'b0;
        end
        if (p == 6) width_acc = {24'h0, b};
        if (p == 7) width_acc = width_acc | {16'h0, b, 8'h00};
        // A JPEG outcome inside the signature bytes is parked until byte 8.
        if (candidates[F_JPEG]) begin
          if (p == 2) begin
            parse_phase = PH_JM1;
          end else if (p >= 3 && parse_phase != PH_JHOLD) begin
            if (jpeg_walk_step(b, last, st)) begin
              held_st = st;
              parse_phase = PH_JHOLD;
            end
          end
        end
        if (p == 7) begin
          if (candidates[F_PNG]) begin
            parse_phase = PH_PNG;
            if (last) begin
              hit = 1'b1;
              r = make_result(FMT_PNG, ST_TRUNC, '0, '0);
            end
          end else if (candidates[F_JPEG]) begin
            if (parse_phase == PH_JHOLD) begin
              hit = 1'b1;
              r = make_result(FMT_JPEG, held_st, width_acc, height_acc);
            end
          end else if (candidates[F_GIF89] || candidates[F_GIF87]) begin
            parse_phase = PH_GIF;
            if (last) begin
              hit = 1'b1;
              r = make_result(FMT_GIF, ST_TRUNC, '0, '0);
            end
          end else begin
            hit = 1'b1;
            r = make_result(FMT_UNKNOWN, ST_UNK_SIG, '0, '0);
          end
        end else if (last) begin
          hit = 1'b1;
          r = make_result(FMT_UNKNOWN, ST_SHORT, '0, '0);
        end
      end else if (parse_phase == PH_PNG) begin
        if (byte_pos >= 12 && byte_pos <= 15 && b != IHDR_NAME[byte_pos[1:0]]) begin
          hit = 1'b1;
          r = make_result(FMT_PNG, ST_BAD_IHDR, '0, '0);
        end else if (byte_pos >= 16 && byte_pos <= 19) begin
          width_acc = (byte_pos == 16) ? {24'h0, b} : {width_acc[23:0], b};
        end else if (byte_pos >= 20 && byte_pos <= 23) begin
          height_acc = (byte_pos == 20) ? {24'h0, b} : {height_acc[23:0], b};
          if (byte_pos == 23) begin
            hit = 1'b1;
            r = make_result(FMT_PNG, ST_OK, width_acc, height_acc);
          end
        end
        if (!hit && last) begin
          hit = 1'b1;
          r = make_result(FMT_PNG, ST_TRUNC, '0, '0);
        end
      end else if (parse_phase == PH_GIF) begin
        if (byte_pos == 8) begin
          height_acc = {24'h0, b};
          if (last) begin
            hit = 1'b1;
            r = make_result(FMT_GIF, ST_TRUNC, '0, '0);
          end
        end else begin
          height_acc = height_acc | {16'h0, b, 8'h00};
          hit = 1'b1;
          r = make_result(FMT_GIF, ST_OK, width_acc, height_acc);
        end
      end else if (jpeg_walk_step(b, last, st)) begin
        hit = 1'b1;
        r = make_result(FMT_JPEG, st, width_acc, height_acc);
      end
      if (hit) decided = 1'b1;
    end
    if (byte_pos != '1) byte_pos = byte_pos + 32'd1;
    if (last) clear_parser();
    return hit;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input bit last, input bit has_typed,
                           input header_result_t typed_res);
    header_result_t predicted;
    bit             hit;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    hit = predict_header_byte(b, last, predicted);
    if (has_typed) header_expect_q.push_back(typed_res);
    else if (hit) header_expect_q.push_back(predicted);
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    while (header_expect_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] dim_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Builds one file in file_q; body_len counts the bytes the parser looks at.
  task automatic make_random_file(output int body_len);
    int         kind;
    int         nseg;
    int         seg_len;
    int         pick;
    int         idx;
    logic [7:0] code;
    file_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      for (int i = 0; i < 8; i++) file_q.push_back(PNG_SIG[i]);
      repeat (4) file_q.push_back(8'($urandom));
      for (int i = 0; i < 4; i++) file_q.push_back(IHDR_NAME[i]);
      repeat (8) file_q.push_back(dim_byte());
      if ($urandom_range(0, 7) == 0) begin
        idx = 12 + $urandom_range(0, 3);
        file_q[idx] = file_q[idx] ^ 8'($urandom_range(1, 255));
      end
    end else if (kind < 60) begin
      file_q.push_back(JPEG_MARK);
      file_q.push_back(JPEG_SOI);
      nseg = $urandom_range(0, 3);
      repeat (nseg) begin
        if ($urandom_range(0, 15) == 0) file_q.push_back(8'($urandom_range(0, 254)));
        else file_q.push_back(JPEG_MARK);
        code = 8'($urandom);
        if (code >= SOF_FIRST && code <= SOF_LAST) code = code ^ 8'h10;
        file_q.push_back(code);
        pick = $urandom_range(0, 39);
        if (pick == 0) seg_len = 256 + $urandom_range(0, 40);
        else if (pick < 3) seg_len = $urandom_range(0, 1);
        else seg_len = $urandom_range(2, 8);
        file_q.push_back(8'(seg_len >> 8));
        file_q.push_back(8'(seg_len));
        for (int i = 2; i < seg_len; i++) file_q.push_back(8'($urandom));
      end
      file_q.push_back(JPEG_MARK);
      file_q.push_back(SOF_FIRST + 8'($urandom_range(0, 3)));
      file_q.push_back(8'h00);
      file_q.push_back(8'h11);
      file_q.push_back(8'h08);
      repeat (4) file_q.push_back(dim_byte());
    end else if (kind < 85) begin
      for (int i = 0; i < 6; i++) begin
        file_q.push_back($urandom_range(0, 1) ? GIF89_SIG[i] : GIF87_SIG[i]);
      end
      repeat (4) file_q.push_back(dim_byte());
    end else begin
      repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
    end
    // A damaged early byte now and then turns a good file into an unknown or broken one.
    if (kind < 85 && $urandom_range(0, 9) == 0) begin
      idx = $urandom_range(0, 5);
      file_q[idx] = file_q[idx] ^ 8'($urandom_range(1, 255));
    end
    if ($urandom_range(0, 3) == 0) begin
      pick = $urandom_range(1, file_q.size());
      while (file_q.size() > pick) void'(file_q.pop_back());
      body_len = file_q.size();
    end else begin
      body_len = file_q.size();
      repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
    end
  endtask

  // Receiver side: random stalls, and one long hold-off on request.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold_off_req) @(negedge clk_i);
        hold_off_req = 0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    header_result_t got;
    header_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.fmt = format_e'(m_axis_tdata_o[1:0]);
      got.st  = status_e'(m_axis_tdata_o[4:2]);
      got.w   = m_axis_tdata_o[36:5];
      got.h   = m_axis_tdata_o[68:37];
      if (header_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h",
                 $time, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = header_expect_q.pop_front();
        if (got.fmt !== want.fmt) begin
          $display("%0t: format expected %0d actual %0d", $time, want.fmt, got.fmt);
          mismatch_count++;
        end
        if (got.st !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          mismatch_count++;
        end
        if (got.w !== want.w) begin
          $display("%0t: width expected %h actual %h", $time, want.w, got.w);
          mismatch_count++;
        end
        if (got.h !== want.h) begin
          $display("%0t: height expected %h actual %h", $time, want.h, got.h);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    header_result_t no_result;
    int             stage;
    int             bytes_offered;
    int             body_len;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    no_result       = make_result(FMT_UNKNOWN, ST_OK, '0, '0);
    stage           = 0;
    bytes_offered   = 0;
    clear_parser();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].has_exp,
                make_result(DIRECTED_ROWS[i].fmt, DIRECTED_ROWS[i].st, '0, '0));
    end

    while (bytes_offered < 800) begin
      if (stage == 0 && bytes_offered >= 270) begin
        wait_results_drained();
        src_idle_pct = 77;
        snk_idle_pct = 35;
        // The result register fills during this stall and the input backs up.
        hold_off_req = 200;
        stage = 1;
      end else if (stage == 1 && bytes_offered >= 540) begin
        wait_results_drained();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stage = 2;
      end
      make_random_file(body_len);
      bytes_offered += body_len;
      for (int i = 0; i < file_q.size(); i++) begin
        send_byte(file_q[i], i == file_q.size() - 1, 1'b0, no_result);
      end
    end

    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // This timeout allows far more time than the slowest legal run needs.
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
